@@ design/assert_macros.svh @@
// Assertion macros used by cross_covariance_accumulator_unit.
// Depends on nothing; define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/ccov_pkg.sv @@
// Types and constants of the cross-covariance accumulator.
// Depends on nothing.
package ccov_pkg;
    localparam int CoordWidth = 24;
    localparam int MaxParticles = 65536;
    localparam int CountWidth = $clog2(MaxParticles + 1);
    localparam int SumWidth = 40;
    localparam int ProdWidth = 2 * CoordWidth;
    localparam int QuotWidth = 2 * SumWidth;
    localparam int MulDigit = 8;
    localparam int MulSteps = SumWidth / MulDigit;
    localparam int DivSteps = QuotWidth;
    localparam int StepWidth = $clog2(DivSteps + 1);

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL,
        ST_MUL_STEP,
        ST_DIV,
        ST_FIX,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic accum;
        logic clear;
        logic mul_start;
        logic mul_step;
        logic div_step;
        logic fix;
        logic entry_next;
    } ccov_cmd_t;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic       full;
    } ccov_stat_t;
endpackage

@@ design/ccov_if.sv @@
// Valid/ready channel interface carrying a request payload.
// Depends on nothing.
interface ccov_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/cross_covariance_accumulator_unit.sv @@
// Accumulation takes one request per cycle; the last request then yields
// nine entries in turn, each through a load, a multiply, a divide-by-N, a
// saturate and a send step, the send waiting while the receiver is not ready.
// No request is taken from the last request until the ninth entry has gone.
// Reset (rst_n low, asynchronous) clears all sums, the count and control.
`include "assert_macros.svh"
module cross_covariance_accumulator_unit (
    input logic clk,
    input logic rst_n,
    ccov_if.sink   in_ch,
    ccov_if.source out_ch
);
    import ccov_pkg::*;

    ccov_cmd_t cmd;
    ccov_stat_t stat;
    logic signed [CoordWidth-1:0] pos [3];
    logic signed [CoordWidth-1:0] refc [3];
    logic signed [63:0] value;

    assign pos[0] = in_ch.data.pos_x;
    assign pos[1] = in_ch.data.pos_y;
    assign pos[2] = in_ch.data.pos_z;
    assign refc[0] = in_ch.data.ref_x;
    assign refc[1] = in_ch.data.ref_y;
    assign refc[2] = in_ch.data.ref_z;

    ccov_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_last(in_ch.data.last_item), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    ccov_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .pos(pos), .refc(refc), .value(value)
    );

    assign out_ch.data.row_index = stat.row;
    assign out_ch.data.col_index = stat.col;
    assign out_ch.data.matrix_value = value;
    assign out_ch.data.last_entry = (stat.row == 2'd2) && (stat.col == 2'd2);

    `ASSERT_IMPLIES(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)
    `ASSERT_NEXT(a_clear_after_last, clk, rst_n,
        out_ch.valid && out_ch.ready && out_ch.data.last_entry,
        stat.row == 2'd0 && stat.col == 2'd0)
    `ASSERT_IMPLIES(a_row_range, clk, rst_n, out_ch.valid, stat.row != 2'd3 && stat.col != 2'd3)
endmodule

@@ design/ccov_datapath.sv @@
// Accumulators, serial multiplier/divider for the correction and saturation.
// Depends on ccov_pkg.
module ccov_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ccov_pkg::ccov_cmd_t                   cmd,
    output ccov_pkg::ccov_stat_t                  stat,
    input  logic signed [ccov_pkg::CoordWidth-1:0] pos [3],
    input  logic signed [ccov_pkg::CoordWidth-1:0] refc [3],
    output logic signed [63:0]                    value
);
    import ccov_pkg::*;

    logic signed [63:0] cross_reg [9];
    logic signed [SumWidth-1:0] rsum_reg [3];
    logic signed [SumWidth-1:0] psum_reg [3];
    logic [CountWidth-1:0] count_reg;
    logic [1:0] row_reg, col_reg;
    logic [ProdWidth-1:0] prod_reg [9];
    logic prod_vld_reg;
    logic [QuotWidth-1:0] num_reg, quot_reg;
    logic [SumWidth-1:0] mcand_reg, mplier_reg;
    logic [CountWidth:0] rem_reg;
    logic neg_reg;
    logic signed [63:0] value_reg;
    logic [SumWidth-1:0] mag_a, mag_b;
    logic [SumWidth+MulDigit-1:0] part;
    logic [3:0] idx;
    logic [CountWidth:0] rem_sh;
    logic signed [QuotWidth:0] qs, diff;

    assign stat.row = row_reg;
    assign stat.col = col_reg;
    assign stat.full = (count_reg == CountWidth'(MaxParticles));
    assign value = value_reg;
    assign idx = 4'(row_reg) * 4'd3 + 4'(col_reg);
    assign mag_a = rsum_reg[row_reg][SumWidth-1] ? SumWidth'(-rsum_reg[row_reg])
                                                 : SumWidth'(rsum_reg[row_reg]);
    assign mag_b = psum_reg[col_reg][SumWidth-1] ? SumWidth'(-psum_reg[col_reg])
                                                 : SumWidth'(psum_reg[col_reg]);
    assign part = mcand_reg * mplier_reg[SumWidth-1 -: MulDigit];
    assign rem_sh = {rem_reg[CountWidth-1:0], num_reg[QuotWidth-1]};
    assign qs = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
    assign diff = (QuotWidth+1)'(cross_reg[idx]) - qs;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            prod_reg[i] <= ProdWidth'($signed(refc[i/3]) * $signed(pos[i%3]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++) cross_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rsum_reg[i] <= '0;
                psum_reg[i] <= '0;
            end
            count_reg <= '0;
            prod_vld_reg <= 1'b0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            prod_vld_reg <= cmd.accum && !stat.full;
            if (cmd.accum && !stat.full)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rsum_reg[i] <= rsum_reg[i] + SumWidth'(refc[i]);
                    psum_reg[i] <= psum_reg[i] + SumWidth'(pos[i]);
                end
                count_reg <= count_reg + 1'b1;
            end
            if (prod_vld_reg)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    cross_reg[i] <= cross_reg[i] + 64'($signed(prod_reg[i]));
                end
            end
            if (cmd.entry_next)
            begin
                if (col_reg == 2'd2)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                end
                else
                begin
                    col_reg <= col_reg + 2'd1;
                end
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < 9; i++) cross_reg[i] <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    rsum_reg[i] <= '0;
                    psum_reg[i] <= '0;
                end
                count_reg <= '0;
                row_reg <= '0;
                col_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mcand_reg <= mag_a;
            mplier_reg <= mag_b;
            num_reg <= '0;
            quot_reg <= '0;
            rem_reg <= '0;
            neg_reg <= rsum_reg[row_reg][SumWidth-1] ^ psum_reg[col_reg][SumWidth-1];
        end
        else if (cmd.mul_step)
        begin
            num_reg <= {num_reg[QuotWidth-MulDigit-1:0], {MulDigit{1'b0}}}
                       + QuotWidth'(part);
            mplier_reg <= {mplier_reg[SumWidth-MulDigit-1:0], {MulDigit{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[QuotWidth-2:0], 1'b0};
            if (count_reg != '0 && rem_sh >= (CountWidth+1)'(count_reg))
            begin
                rem_reg <= rem_sh - (CountWidth+1)'(count_reg);
                quot_reg <= {quot_reg[QuotWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quot_reg <= {quot_reg[QuotWidth-2:0], 1'b0};
            end
        end
        if (cmd.fix)
        begin
            if (diff > $signed((QuotWidth+1)'(64'sh7FFFFFFFFFFFFFFF)))
                value_reg <= 64'sh7FFFFFFFFFFFFFFF;
            else if (diff < -$signed((QuotWidth+1)'(64'sh7FFFFFFFFFFFFFFF)) - 1)
                value_reg <= 64'sh8000000000000000;
            else
                value_reg <= 64'(diff);
        end
    end
endmodule

@@ design/ccov_ctrl.sv @@
// Sequencer: accumulate, then per entry multiply, divide, fix and send.
// Depends on ccov_pkg.
module ccov_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ccov_pkg::ccov_stat_t  stat,
    output ccov_pkg::ccov_cmd_t   cmd
);
    import ccov_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [StepWidth-1:0] step_reg, step_next;
    logic pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            pend_reg <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        pend_next = 1'b0;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                in_ready = !pend_reg;
                if (pend_reg)
                begin
                    state_next = ST_MUL;
                end
                else if (in_valid)
                begin
                    cmd.accum = 1'b1;
                    pend_next = in_last;
                end
            end
            ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                step_next = '0;
                state_next = ST_MUL_STEP;
            end
            ST_MUL_STEP:
            begin
                cmd.mul_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == StepWidth'(MulSteps - 1))
                begin
                    step_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == StepWidth'(DivSteps - 1))
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.row == 2'd2 && stat.col == 2'd2)
                    begin
                        cmd.clear = 1'b1;
                        state_next = ST_ACCUM;
                    end
                    else
                    begin
                        cmd.entry_next = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end
endmodule
